FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and helpers for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA   = 3'd0,
    K_CLOSE  = 3'd1,
    K_NOOPEN = 3'd2,
    K_BADESC = 3'd3,
    K_BADHEX = 3'd4,
    K_EARLY  = 3'd5
  } kind_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // one queue entry: the whole group of results caused by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    kind_t      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } push_t;

  // bit 4 set when the byte is a hex digit, low bits its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic entry_t utf8_encode(input logic [15:0] cp);
    entry_t e;
    e.kind = K_DATA;
    e.b1 = 8'h00;
    e.b2 = 8'h00;
    if (cp < 16'h0080) begin
      e.cnt = 2'd1;
      e.b0 = cp[7:0];
    end else if (cp < 16'h0800) begin
      e.cnt = 2'd2;
      e.b0 = {3'b110, cp[10:6]};
      e.b1 = {2'b10, cp[5:0]};
    end else begin
      e.cnt = 2'd3;
      e.b0 = {4'b1110, cp[15:12]};
      e.b1 = {2'b10, cp[11:6]};
      e.b2 = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

FILE: rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// input byte channel: raw text byte and end-of-stream flag
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

FILE: rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// result channel: decoded byte, result kind and last flag
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

FILE: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// parser state machine: takes input beats, decodes escapes, pushes result groups
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic              clk,
  input  logic              rst,
  jsu_in_if.sink            in_ch,
  input  logic              q_full,
  output jsu_pkg::push_t    push
);

  jsu_pkg::phase_t phase;
  jsu_pkg::phase_t phase_next;
  logic [1:0]      hex_count;
  logic [1:0]      hex_count_next;
  logic [15:0]     code_accum;
  logic [15:0]     code_accum_next;
  logic            take;
  logic [4:0]      hv;
  logic [15:0]     code_full;

  assign in_ch.ready = !q_full;
  assign take = in_ch.valid && !q_full;
  assign hv = jsu_pkg::hex_value(in_ch.in_byte);
  assign code_full = {code_accum[11:0], hv[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsu_pkg::PH_WAIT;
      hex_count <= 2'd0;
      code_accum <= 16'd0;
    end else if (take) begin
      phase <= phase_next;
      hex_count <= hex_count_next;
      code_accum <= code_accum_next;
    end
  end

  always_comb begin
    phase_next = phase;
    hex_count_next = hex_count;
    code_accum_next = code_accum;
    if (in_ch.stream_end) begin
      phase_next = jsu_pkg::PH_WAIT;
      hex_count_next = 2'd0;
      code_accum_next = 16'd0;
    end else begin
      case (phase)
        jsu_pkg::PH_WAIT: begin
          if (in_ch.in_byte == jsu_pkg::CH_QUOTE) begin
            phase_next = jsu_pkg::PH_BODY;
            hex_count_next = 2'd0;
            code_accum_next = 16'd0;
          end
        end
        jsu_pkg::PH_BODY: begin
          if (in_ch.in_byte == jsu_pkg::CH_QUOTE) begin
            phase_next = jsu_pkg::PH_WAIT;
          end else if (in_ch.in_byte == jsu_pkg::CH_BSLASH) begin
            phase_next = jsu_pkg::PH_ESC;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (in_ch.in_byte == jsu_pkg::CH_U) begin
            phase_next = jsu_pkg::PH_HEX;
            hex_count_next = 2'd0;
            code_accum_next = 16'd0;
          end else if (in_ch.in_byte inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                       jsu_pkg::CH_SLASH, jsu_pkg::CH_B, jsu_pkg::CH_F,
                       jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T}) begin
            phase_next = jsu_pkg::PH_BODY;
          end else begin
            phase_next = jsu_pkg::PH_WAIT;
          end
        end
        jsu_pkg::PH_HEX: begin
          if (!hv[4]) begin
            phase_next = jsu_pkg::PH_WAIT;
            hex_count_next = 2'd0;
            code_accum_next = 16'd0;
          end else if (hex_count == 2'd3) begin
            phase_next = jsu_pkg::PH_BODY;
            hex_count_next = 2'd0;
            code_accum_next = 16'd0;
          end else begin
            hex_count_next = hex_count + 2'd1;
            code_accum_next = code_full;
          end
        end
        default: begin
          phase_next = jsu_pkg::PH_WAIT;
        end
      endcase
    end
  end

  always_comb begin
    jsu_pkg::entry_t e;
    logic            has;
    e.cnt = 2'd1;
    e.kind = jsu_pkg::K_DATA;
    e.b0 = 8'h00;
    e.b1 = 8'h00;
    e.b2 = 8'h00;
    has = 1'b0;
    if (in_ch.stream_end) begin
      has = (phase != jsu_pkg::PH_WAIT);
      e.kind = jsu_pkg::K_EARLY;
    end else begin
      case (phase)
        jsu_pkg::PH_WAIT: begin
          has = (in_ch.in_byte != jsu_pkg::CH_QUOTE);
          e.kind = jsu_pkg::K_NOOPEN;
        end
        jsu_pkg::PH_BODY: begin
          if (in_ch.in_byte == jsu_pkg::CH_QUOTE) begin
            has = 1'b1;
            e.kind = jsu_pkg::K_CLOSE;
          end else if (in_ch.in_byte != jsu_pkg::CH_BSLASH) begin
            has = 1'b1;
            e.b0 = in_ch.in_byte;
          end
        end
        jsu_pkg::PH_ESC: begin
          has = 1'b1;
          case (in_ch.in_byte)
            jsu_pkg::CH_QUOTE:  e.b0 = 8'h22;
            jsu_pkg::CH_BSLASH: e.b0 = 8'h5c;
            jsu_pkg::CH_SLASH:  e.b0 = 8'h2f;
            jsu_pkg::CH_B:      e.b0 = 8'h08;
            jsu_pkg::CH_F:      e.b0 = 8'h0c;
            jsu_pkg::CH_N:      e.b0 = 8'h0a;
            jsu_pkg::CH_R:      e.b0 = 8'h0d;
            jsu_pkg::CH_T:      e.b0 = 8'h09;
            jsu_pkg::CH_U:      has = 1'b0;
            default:            e.kind = jsu_pkg::K_BADESC;
          endcase
        end
        jsu_pkg::PH_HEX: begin
          if (!hv[4]) begin
            has = 1'b1;
            e.kind = jsu_pkg::K_BADHEX;
          end else if (hex_count == 2'd3) begin
            has = 1'b1;
            e = jsu_pkg::utf8_encode(code_full);
          end
        end
        default: begin
          has = (in_ch.in_byte != jsu_pkg::CH_QUOTE);
          e.kind = jsu_pkg::K_NOOPEN;
        end
      endcase
    end
    push.valid = take && has;
    push.data = e;
  end

endmodule

FILE: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// short queue of result groups between the parser and the output sequencer
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic            clk,
  input  logic            rst,
  input  jsu_pkg::push_t  push,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output jsu_pkg::entry_t head
);

  jsu_pkg::entry_t                 mem [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QPTR_W-1:0]      wr_ptr;
  logic [jsu_pkg::QPTR_W-1:0]      rd_ptr;
  logic [jsu_pkg::QPTR_W:0]        fill;
  logic                            do_pop;

  assign full = (fill == (jsu_pkg::QPTR_W+1)'(jsu_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head = mem[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push.valid) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// output sequencer: sends each queued group as one to three result beats
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  jsu_pkg::entry_t head,
  output logic            pop,
  jsu_out_if.source       out_ch
);

  logic [1:0] idx;
  logic       is_last;
  logic       fire;

  assign is_last = (idx == head.cnt - 2'd1);
  assign fire = !empty && out_ch.ready;
  assign pop = fire && is_last;

  assign out_ch.valid = !empty;
  assign out_ch.kind = head.kind;
  assign out_ch.last = is_last;

  always_comb begin
    case (idx)
      2'd0:    out_ch.out_byte = head.b0;
      2'd1:    out_ch.out_byte = head.b1;
      2'd2:    out_ch.out_byte = head.b2;
      default: out_ch.out_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

FILE: rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// unescapes a quoted json string byte stream, \u escapes emitted as utf-8
//
//   channel  dir  payload                      handshake
//   in_ch    in   in_byte[7:0], stream_end     valid/ready
//   out_ch   out  out_byte[7:0], kind[2:0], last  valid/ready
//
// one input beat per cycle while the four-entry result queue has room
// each input beat yields zero to three output beats; the output side sends
// one beat per cycle while out_ch.ready is high, so a utf-8 group goes out in order
// synchronous reset returns the parser to waiting for an opening quote
// a stalled output fills the queue, then in_ch.ready drops
// ----------------------------------------------------------------------------
module json_string_unescape (
  input logic       clk,
  input logic       rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  jsu_pkg::push_t  push;
  jsu_pkg::entry_t head;
  logic            full;
  logic            empty;
  logic            pop;

  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (full),
    .push   (push)
  );

  jsu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  jsu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// port-level checks on the result channel of the unescaper
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [2:0] kind,
  input logic       last
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(last))
    else $error("stalled result beat changed");

  // status results are single beats with a zero byte
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != jsu_pkg::K_DATA) |-> last && (out_byte == 8'h00))
    else $error("status result not a single zero beat");

  // only multi-byte utf-8 leads to a non-final beat
  a_multi: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (kind == jsu_pkg::K_DATA) && out_byte[7])
    else $error("non-final beat is not part of a utf-8 sequence");

  // a beat after a non-final beat is a continuation byte
  a_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && (out_byte[7:6] == 2'b10))
    else $error("utf-8 sequence broken");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .kind      (out_ch.kind),
  .last      (out_ch.last)
);
